### src/rcq_pkg.sv
// Shared widths, defaults, configuration indexes and stage types for the crop quantizer.
package rcq_pkg;

  localparam int PIX_W   = 16;
  localparam int DIM_W   = 10;
  localparam int SCALE_W = 24;
  localparam int Q_W     = 8;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;

  localparam int CROP_WIDTH_DEF  = 240;
  localparam int CROP_HEIGHT_DEF = 240;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = DIM_W'(320);
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = DIM_W'(240);
  localparam logic [SCALE_W-1:0] SCALE_RST        = SCALE_W'(65536);
  localparam logic [Q_W-1:0]     Q_OFFSET_RST     = '0;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SCALE        = 2'd2,
    CFG_Q_OFFSET     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [SCALE_W-1:0] scale_multiplier;
    logic signed [Q_W-1:0] q_offset;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

### src/rcq_if.sv
// Valid/ready channel interfaces for the pixel input and the quantized result.
interface rcq_pix_if;
  import rcq_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface rcq_q_if;
  import rcq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] red_q;
  logic signed [Q_W-1:0] green_q;
  logic signed [Q_W-1:0] blue_q;
  logic                  crop_last;
  modport source(output valid, output red_q, output green_q, output blue_q,
                 output crop_last, input ready);
  modport sink(input valid, input red_q, input green_q, input blue_q,
               input crop_last, output ready);
endinterface

### src/rgb565_center_crop_int8_quantizer.sv
// Top level of the centered-crop RGB565 to int8 quantizer.
// Pixels of the whole frame arrive in raster order on in_pix, one word per
// valid/ready handshake. Only pixels inside a CROP_WIDTH by CROP_HEIGHT
// window centered in the frame produce a word on out_q; the others are
// consumed and dropped. Each result carries the three quantized channels and
// crop_last, which marks the final pixel of the window.
// A pixel is taken every cycle while the output side keeps up. A kept pixel
// passes through the input register and then the result register before it
// is presented on out_q; the multiply, rounding and saturation sit between
// the input register and the result register.
// When the receiver stalls, the result register holds its word and the input
// register keeps taking pixels until it holds a kept one; then in_pix.ready
// drops.
// Configuration words on cfg_we, cfg_index and cfg_data set the frame size,
// the scale multiplier and the zero point; the user is to write them only
// while the block is idle, which the block itself does not enforce. They do
// not clear the row and column counters. Reset restores the default
// configuration, clears both counters and empties both registers.
module rgb565_center_crop_int8_quantizer #(
  parameter int CROP_WIDTH  = rcq_pkg::CROP_WIDTH_DEF,
  parameter int CROP_HEIGHT = rcq_pkg::CROP_HEIGHT_DEF,
  parameter int FRAC_BITS   = rcq_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rcq_pix_if.sink                   in_pix,
  rcq_q_if.source                   out_q,
  input  logic                      cfg_we,
  input  logic [rcq_pkg::IDX_W-1:0] cfg_index,
  input  logic [rcq_pkg::CFG_W-1:0] cfg_data
);
  import rcq_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  stage_ctl_t       s1_ctl;
  logic [PIX_W-1:0] s1_pixel;
  logic             s2_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  cfg_nxt.frame_width      = cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_nxt.frame_height     = cfg_data[DIM_W-1:0];
        CFG_SCALE:        cfg_nxt.scale_multiplier = cfg_data[SCALE_W-1:0];
        CFG_Q_OFFSET:     cfg_nxt.q_offset         = $signed(cfg_data[Q_W-1:0]);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width      <= FRAME_WIDTH_RST;
      cfg_r.frame_height     <= FRAME_HEIGHT_RST;
      cfg_r.scale_multiplier <= SCALE_RST;
      cfg_r.q_offset         <= Q_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcq_crop_track #(
    .CROP_WIDTH (CROP_WIDTH),
    .CROP_HEIGHT(CROP_HEIGHT)
  ) u_crop_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_pixel  (in_pix.pixel),
    .down_ready(s2_ready),
    .s1_ctl    (s1_ctl),
    .s1_pixel  (s1_pixel)
  );

  rcq_quant #(
    .FRAC_BITS(FRAC_BITS)
  ) u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s1_ctl   (s1_ctl),
    .s1_pixel (s1_pixel),
    .s2_ready (s2_ready),
    .out_valid(out_q.valid),
    .out_ready(out_q.ready),
    .red_q    (out_q.red_q),
    .green_q  (out_q.green_q),
    .blue_q   (out_q.blue_q),
    .crop_last(out_q.crop_last)
  );

endmodule

### src/rcq_crop_track.sv
// Row and column tracking, crop window test and input register stage.
module rcq_crop_track #(
  parameter int CROP_WIDTH  = rcq_pkg::CROP_WIDTH_DEF,
  parameter int CROP_HEIGHT = rcq_pkg::CROP_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rcq_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rcq_pkg::PIX_W-1:0] in_pixel,
  input  logic                      down_ready,
  output rcq_pkg::stage_ctl_t       s1_ctl,
  output logic [rcq_pkg::PIX_W-1:0] s1_pixel
);
  import rcq_pkg::*;

  localparam int EXT_W = DIM_W + 1;
  localparam logic [EXT_W-1:0] CW = EXT_W'(CROP_WIDTH);
  localparam logic [EXT_W-1:0] CH = EXT_W'(CROP_HEIGHT);

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  stage_ctl_t       s1_r, s1_nxt;
  logic [PIX_W-1:0] s1_pixel_r;

  logic [EXT_W-1:0] fw_ext, fh_ext, ox, oy, col_ext, row_ext, col_inc, row_inc;
  logic             in_window, last, accept;

  always_comb begin
    fw_ext    = {1'b0, cfg.frame_width};
    fh_ext    = {1'b0, cfg.frame_height};
    ox        = (fw_ext >= CW) ? ((fw_ext - CW) >> 1) : '0;
    oy        = (fh_ext >= CH) ? ((fh_ext - CH) >> 1) : '0;
    col_ext   = {1'b0, col_r};
    row_ext   = {1'b0, row_r};
    col_inc   = col_ext + EXT_W'(1);
    row_inc   = row_ext + EXT_W'(1);
    in_window = (col_ext >= ox) && (col_ext < ox + CW) &&
                (row_ext >= oy) && (row_ext < oy + CH);
    last      = (col_ext == ox + CW - EXT_W'(1)) && (row_ext == oy + CH - EXT_W'(1));
  end

  assign in_ready = !s1_r.valid || down_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= fw_ext) begin
        col_nxt = '0;
        row_nxt = (row_inc >= fh_ext) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    s1_nxt = s1_r;
    if (in_ready) begin
      s1_nxt.valid = accept && in_window;
      s1_nxt.last  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_r  <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_pixel_r <= in_pixel;
    end
  end

  assign s1_ctl   = s1_r;
  assign s1_pixel = s1_pixel_r;

endmodule

### src/rcq_quant.sv
// Channel widening, fixed-point scaling, rounding, zero point and int8 saturation.
module rcq_quant #(
  parameter int FRAC_BITS = rcq_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcq_pkg::cfg_t                    cfg,
  input  rcq_pkg::stage_ctl_t              s1_ctl,
  input  logic [rcq_pkg::PIX_W-1:0]        s1_pixel,
  output logic                             s2_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rcq_pkg::Q_W-1:0]   red_q,
  output logic signed [rcq_pkg::Q_W-1:0]   green_q,
  output logic signed [rcq_pkg::Q_W-1:0]   blue_q,
  output logic                             crop_last
);
  import rcq_pkg::*;

  localparam int PROD_W = Q_W + SCALE_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int SUM_W  = RND_W + 1;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(127);
  localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(128);

  function automatic logic signed [Q_W-1:0] quant(
    input logic [Q_W-1:0] c8,
    input logic [SCALE_W-1:0] m,
    input logic signed [Q_W-1:0] zp
  );
    logic [PROD_W-1:0]       prod;
    logic [RND_W-1:0]        rnd;
    logic signed [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]   res;
    prod = PROD_W'(c8) * PROD_W'(m);
    rnd  = ({1'b0, prod} + HALF) >> FRAC_BITS;
    sum  = $signed({1'b0, rnd}) + SUM_W'(zp);
    if (sum > Q_MAX) begin
      res = Q_W'(127);
    end else if (sum < Q_MIN) begin
      res = Q_W'(Q_MIN);
    end else begin
      res = sum[Q_W-1:0];
    end
    return res;
  endfunction

  logic                  valid_r, valid_nxt;
  logic signed [Q_W-1:0] red_r, green_r, blue_r;
  logic                  last_r;
  logic [Q_W-1:0]        r8, g8, b8;

  assign r8 = {s1_pixel[15:11], 3'b000};
  assign g8 = {s1_pixel[10:5], 2'b00};
  assign b8 = {s1_pixel[4:0], 3'b000};

  assign s2_ready  = !valid_r || out_ready;
  assign valid_nxt = s2_ready ? s1_ctl.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_ctl.valid) begin
      red_r   <= quant(r8, cfg.scale_multiplier, cfg.q_offset);
      green_r <= quant(g8, cfg.scale_multiplier, cfg.q_offset);
      blue_r  <= quant(b8, cfg.scale_multiplier, cfg.q_offset);
      last_r  <= s1_ctl.last;
    end
  end

  assign out_valid = valid_r;
  assign red_q     = red_r;
  assign green_q   = green_r;
  assign blue_q    = blue_r;
  assign crop_last = last_r;

endmodule

### verif/rcq_quant_monitor.sv
// Monitor that predicts the cropped, quantized words and compares them with the block's output.
`timescale 1ns / 1ps

module rcq_quant_monitor
  import rcq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rcq_pix_if               pix,
  rcq_q_if                 q,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               words_due,
  output int               pixels_kept,
  output int               words_seen,
  output int               window_ends
);

  typedef struct packed {
    logic signed [Q_W-1:0] red;
    logic signed [Q_W-1:0] green;
    logic signed [Q_W-1:0] blue;
    logic                  last;
  } q_word_t;

  q_word_t quant_due[$];

  logic [DIM_W-1:0]      frame_w;
  logic [DIM_W-1:0]      frame_h;
  logic [SCALE_W-1:0]    mult;
  logic signed [Q_W-1:0] zp;
  logic [DIM_W-1:0]      col_pos;
  logic [DIM_W-1:0]      row_pos;
  int                    err_cnt;
  int                    kept_cnt;
  int                    seen_cnt;
  int                    end_cnt;

  function automatic logic signed [Q_W-1:0] quantize_channel(input logic [7:0] c8);
    longint acc;
    acc = (longint'(c8) * longint'(mult) + (longint'(1) << (FRAC_BITS_DEF - 1)))
          >>> FRAC_BITS_DEF;
    acc = acc + longint'(zp);
    if (acc > 127) begin
      acc = 127;
    end else if (acc < -128) begin
      acc = -128;
    end
    return Q_W'(acc);
  endfunction

  function automatic int crop_origin(input int frame, input int crop);
    return (frame < crop) ? 0 : (frame - crop) / 2;
  endfunction

  always @(posedge clk) begin : track
    int      ox;
    int      oy;
    int      c;
    int      r;
    q_word_t want;
    q_word_t got;
    if (!rst_n) begin
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      mult    = SCALE_RST;
      zp      = Q_OFFSET_RST;
      col_pos = '0;
      row_pos = '0;
      quant_due.delete();
      err_cnt  = 0;
      kept_cnt = 0;
      seen_cnt = 0;
      end_cnt  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_w = cfg_data[DIM_W-1:0];
          CFG_FRAME_HEIGHT: frame_h = cfg_data[DIM_W-1:0];
          CFG_SCALE:        mult    = cfg_data[SCALE_W-1:0];
          CFG_Q_OFFSET:     zp      = cfg_data[Q_W-1:0];
          default: ;
        endcase
      end

      if (q.valid && q.ready) begin
        got = '{q.red_q, q.green_q, q.blue_q, q.crop_last};
        seen_cnt++;
        if (got.last) begin
          end_cnt++;
        end
        if (quant_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("Unexpected word %0d: r=%0d g=%0d b=%0d last=%0b",
                     seen_cnt, got.red, got.green, got.blue, got.last);
          end
        end else begin
          want = quant_due.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display({"Mismatch on word %0d: expected r=%0d g=%0d b=%0d last=%0b, ",
                        "got r=%0d g=%0d b=%0d last=%0b"},
                       seen_cnt, want.red, want.green, want.blue, want.last,
                       got.red, got.green, got.blue, got.last);
            end
          end
        end
      end

      if (pix.valid && pix.ready) begin
        c  = int'(col_pos);
        r  = int'(row_pos);
        ox = crop_origin(int'(frame_w), CROP_WIDTH_DEF);
        oy = crop_origin(int'(frame_h), CROP_HEIGHT_DEF);
        if (c >= ox && c < ox + CROP_WIDTH_DEF &&
            r >= oy && r < oy + CROP_HEIGHT_DEF) begin
          want.red   = quantize_channel({pix.pixel[15:11], 3'b000});
          want.green = quantize_channel({pix.pixel[10:5], 2'b00});
          want.blue  = quantize_channel({pix.pixel[4:0], 3'b000});
          want.last  = (c == ox + CROP_WIDTH_DEF - 1) && (r == oy + CROP_HEIGHT_DEF - 1);
          quant_due.push_back(want);
          kept_cnt++;
        end
        if (c + 1 >= int'(frame_w)) begin
          col_pos = '0;
          if (r + 1 >= int'(frame_h)) begin
            row_pos = '0;
          end else begin
            row_pos = DIM_W'(r + 1);
          end
        end else begin
          col_pos = DIM_W'(c + 1);
        end
      end
    end
    mismatches  <= err_cnt;
    words_due   <= quant_due.size();
    pixels_kept <= kept_cnt;
    words_seen  <= seen_cnt;
    window_ends <= end_cnt;
  end

endmodule

### verif/tb_rgb565_center_crop_int8_quantizer.sv
// Testbench top: drives pixels, configuration and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb_rgb565_center_crop_int8_quantizer;
  import rcq_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEM_TARGET   = 750;
  localparam logic [PIX_W-1:0] CORNER_PX [8] = '{
    16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8410, 16'h0841, 16'h7BEF
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int mismatches;
  int words_due;
  int pixels_kept;
  int words_seen;
  int window_ends;
  int idle_cycles = 0;
  int pixels_sent = 0;
  int reg_writes = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  rcq_pix_if pix_ch ();
  rcq_q_if   q_ch ();

  rgb565_center_crop_int8_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_q     (q_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcq_quant_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_ch),
    .q           (q_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .words_due   (words_due),
    .pixels_kept (pixels_kept),
    .words_seen  (words_seen),
    .window_ends (window_ends)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (q_ch.valid && q_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("No handshake for %0d cycles, stopping.", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sink_side
    int stall;
    q_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        q_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      q_ch.ready <= 1'b1;
      @(posedge clk);
      while (!q_ch.valid) @(posedge clk);
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count && pixels_sent < ITEM_TARGET; i++) begin
      push_pixel(PIX_W'($urandom));
    end
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Bits above the register width are filled at random; the block must ignore them.
  task automatic set_frame(input int w, input int h);
    set_reg(CFG_FRAME_WIDTH, {14'($urandom), DIM_W'(w)});
    set_reg(CFG_FRAME_HEIGHT, {14'($urandom), DIM_W'(h)});
  endtask

  task automatic set_quant(input logic [SCALE_W-1:0] scale, input logic [Q_W-1:0] zero);
    set_reg(CFG_SCALE, scale);
    set_reg(CFG_Q_OFFSET, {16'($urandom), zero});
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 3))
      0:       return SCALE_W'($urandom);
      1:       return SCALE_W'($urandom_range(0, 'h1FFFF));
      2:       return SCALE_W'($urandom_range(0, 'h3FFF));
      default: return SCALE_W'($urandom_range('h100, 'h1000));
    endcase
  endfunction

  initial begin : stimulus
    int kind;
    int choice;
    int hf;
    int wf;
    int ox;
    int oy;
    int top_row;
    int target;
    int span;
    bit first_sweep;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_FRAME_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default frame: the first pixels lie left of the window and are dropped.
    push_random(3);
    drain();
    // Frame smaller than the crop, with the column already past the new width.
    set_frame(2, 3);
    for (int i = 0; i < 8; i++) begin
      push_pixel(CORNER_PX[i]);
    end
    drain();
    set_quant(24'hFFFFFF, 8'h80);
    for (int i = 0; i < 4; i++) begin
      push_pixel(CORNER_PX[i * 2]);
    end
    drain();
    set_quant(24'h000000, 8'h7F);
    push_pixel(16'hFFFF);
    push_pixel(16'h0000);
    drain();
    // Zero-sized frame wraps on every pixel; a green LSB lands exactly on one half.
    set_quant(24'h002000, 8'h00);
    set_frame(0, 0);
    push_pixel(16'h0020);
    push_pixel(16'h0841);
    push_pixel(16'hFFFF);
    push_pixel(16'h0000);
    drain();

    first_sweep = 1'b1;
    while (pixels_sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      kind = first_sweep ? 0 : $urandom_range(0, 9);
      if (kind < 4) begin
        if (first_sweep) begin
          hf = $urandom_range(240, 300);
          wf = $urandom_range(240, 300);
        end else begin
          hf = ($urandom_range(0, 9) < 7) ? $urandom_range(240, 542) :
                                            $urandom_range(240, 1023);
          wf = ($urandom_range(0, 9) < 7) ? $urandom_range(240, 300) :
                                            $urandom_range(240, 1023);
        end
        oy = (hf - 240) / 2;
        ox = (wf - 240) / 2;
        top_row = (hf - 1 < 390) ? hf - 1 : 390;
        choice = first_sweep ? 0 : $urandom_range(0, 4);
        case (choice)
          0:       target = (oy + 239 <= top_row) ? oy + 239 : top_row;
          1:       target = oy;
          2:       target = (oy > 0) ? oy - 1 : 0;
          3:       target = top_row;
          default: target = $urandom_range(0, top_row);
        endcase
        // Park the counters at the frame origin, then walk down the rows one pixel per row
        // while a tall frame keeps those rows above the window.
        set_frame(1, 1);
        push_random(1);
        drain();
        set_frame(1, 1023);
        push_random(target);
        drain();
        set_frame(wf, hf);
        set_quant(pick_scale(), Q_W'($urandom));
        choice = first_sweep ? 0 : $urandom_range(0, 2);
        case (choice)
          0:       span = ox + 240 + $urandom_range(0, 3);
          1:       span = wf + $urandom_range(1, ox + 250);
          default: span = $urandom_range(1, ox + 240);
        endcase
        for (int i = 0; i < span && pixels_sent < ITEM_TARGET; i++) begin
          push_pixel(PIX_W'($urandom));
          if ($urandom_range(0, 199) == 0) begin
            drain();
          end
        end
        drain();
        first_sweep = 1'b0;
      end else if (kind < 8) begin
        if ($urandom_range(0, 3) == 0) begin
          set_frame($urandom_range(0, 239), $urandom_range(0, 239));
        end else begin
          set_frame($urandom_range(0, 12), $urandom_range(0, 12));
        end
        set_quant(pick_scale(), Q_W'($urandom));
        span = $urandom_range(10, 40);
        for (int i = 0; i < span && pixels_sent < ITEM_TARGET; i++) begin
          push_pixel(PIX_W'($urandom));
          if ($urandom_range(0, 29) == 0) begin
            drain();
          end
        end
        drain();
      end else begin
        set_frame($urandom_range(0, 1023), $urandom_range(0, 1023));
        push_random($urandom_range(5, 30));
        drain();
      end
    end

    drain();
    $display("Sent %0d pixels (%0d inside a crop window) over %0d register writes.",
             pixels_sent, pixels_kept, reg_writes);
    $display("Checked %0d quantized words, %0d of them closing a crop window.",
             words_seen, window_ends);
    if (mismatches == 0 && words_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
